@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the decoder top level.
// Needs clk and rst in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/core/pled_pkg.sv @@
// Types, codes and decode helpers for the packed list entry decoder.
// No dependencies; the decoder modules and the testbench import it.
package pled_pkg;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [3:0] {
    ENC_U7  = 4'd0,
    ENC_I13 = 4'd1,
    ENC_I16 = 4'd2,
    ENC_I24 = 4'd3,
    ENC_I32 = 4'd4,
    ENC_I64 = 4'd5,
    ENC_S6  = 4'd6,
    ENC_S12 = 4'd7,
    ENC_S32 = 4'd8
  } enc_t;

  typedef enum logic [2:0] {
    KIND_HEADER = 3'd0,
    KIND_INT    = 3'd1,
    KIND_BYTE   = 3'd2,
    KIND_EMPTY  = 3'd3,
    KIND_END    = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_TAG     = 3'd1,
    PH_INT     = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_BACKLEN = 3'd5,
    PH_DONE    = 3'd6
  } phase_t;

  typedef struct packed {
    logic is_end;
    enc_t enc;
  } tag_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    tag_t       tag;
  } item_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [63:0] int_value;
    logic [7:0]         payload_byte;
    logic [31:0]        string_length;
    enc_t               encoding;
    logic [15:0]        entry_number;
    logic               last_of_entry;
    logic [31:0]        size_field;
    logic [15:0]        count_field;
  } result_t;

  function automatic logic [3:0] head_size(input enc_t enc);
    case (enc)
      ENC_U7:  return 4'd1;
      ENC_I13: return 4'd2;
      ENC_I16: return 4'd3;
      ENC_I24: return 4'd4;
      ENC_I32: return 4'd5;
      ENC_I64: return 4'd9;
      ENC_S6:  return 4'd1;
      ENC_S12: return 4'd2;
      default: return 4'd5;
    endcase
  endfunction

  function automatic logic [2:0] backlen_count(input logic [32:0] len);
    if (len <= 33'd127)       return 3'd1;
    if (len <= 33'd16383)     return 3'd2;
    if (len <= 33'd2097151)   return 3'd3;
    if (len <= 33'd268435455) return 3'd4;
    return 3'd5;
  endfunction

  function automatic logic [63:0] sign_ext(input logic [63:0] v, input enc_t enc);
    case (enc)
      ENC_I13: return {{51{v[12]}}, v[12:0]};
      ENC_I16: return {{48{v[15]}}, v[15:0]};
      ENC_I24: return {{40{v[23]}}, v[23:0]};
      ENC_I32: return {{32{v[31]}}, v[31:0]};
      default: return v;
    endcase
  endfunction

endpackage

@@ rtl/core/pled_stream_if.sv @@
// Valid/ready channel carrying one payload of type T.
// Depends on nothing; payload types come from pled_pkg at instantiation.
interface pled_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

@@ rtl/core/packed_list_entry_decoder.sv @@
// Channel  | dir  | payload
// stream   | sink | data_byte[8], first_byte
// result   | src  | kind, int_value, payload_byte, string_length, encoding,
//          |      | entry_number, last_of_entry, size_field, count_field
//
// One byte per cycle sustained while the result side is ready; each byte updates the back-stage parser once.
// An accepted byte passes the front register and the queue before its result
// is written to the output register.
// Synchronous reset clears the parser to the header phase; no clearing pass.
// A result stall fills the queue, then the front register, then drops stream.ready.
//
// Top level of the packed list entry decoder; depends on pled_pkg,
// pled_stream_if, pled_front, pled_fifo, pled_back and assert_macros.svh.
`include "assert_macros.svh"

module packed_list_entry_decoder #(
  parameter int QueueDepth = pled_pkg::QUEUE_DEPTH
) (
  input logic           clk,
  input logic           rst,
  pled_stream_if.sink   stream,
  pled_stream_if.source result
);
  import pled_pkg::*;

  localparam int LevelW = $clog2(QueueDepth + 1);

  logic [LevelW-1:0] q_level;
  logic              hdr_out;

  pled_stream_if #(.T(item_t)) fq ();
  pled_stream_if #(.T(item_t)) qb ();

  pled_front u_front (
    .clk    (clk),
    .rst    (rst),
    .stream (stream),
    .push   (fq)
  );

  pled_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (fq),
    .pop   (qb),
    .level (q_level)
  );

  pled_back u_back (
    .clk    (clk),
    .rst    (rst),
    .queue  (qb),
    .result (result)
  );

  assign hdr_out = result.valid && (result.payload.kind == KIND_HEADER);

  `ASSERT_IMPLY(a_level_bound, 1'b1, int'(q_level) <= QueueDepth)
  `ASSERT_IMPLY(a_pop_nonempty, qb.valid && qb.ready, q_level != '0)
  `ASSERT_NEXT(a_front_hold, fq.valid && !fq.ready, fq.valid && $stable(fq.payload))
  `ASSERT_IMPLY(a_header_number, hdr_out, result.payload.entry_number == '0)
endmodule

@@ rtl/core/pled_front.sv @@
// Front stage: registers each input byte and classifies it as a list-pack tag.
// Depends on pled_pkg and pled_stream_if.
module pled_front (
  input logic           clk,
  input logic           rst,
  pled_stream_if.sink   stream,
  pled_stream_if.source push
);
  import pled_pkg::*;

  logic  fvalid;
  item_t fitem;
  tag_t  tag;
  in_t   req;

  function automatic tag_t classify(input logic [7:0] b);
    tag_t t;
    t.is_end = (b == 8'hFF);
    if (b[7] == 1'b0)            t.enc = ENC_U7;
    else if (b[7:6] == 2'b10)    t.enc = ENC_S6;
    else if (b[7:5] == 3'b110)   t.enc = ENC_I13;
    else if (b[7:4] == 4'b1110)  t.enc = ENC_S12;
    else begin
      case (b)
        8'hF1:   t.enc = ENC_I16;
        8'hF2:   t.enc = ENC_I24;
        8'hF3:   t.enc = ENC_I32;
        8'hF4:   t.enc = ENC_I64;
        default: t.enc = ENC_S32;
      endcase
    end
    return t;
  endfunction

  assign req          = stream.payload;
  assign tag          = classify(req.data_byte);
  assign stream.ready = !fvalid || push.ready;
  assign push.valid   = fvalid;
  assign push.payload = fitem;

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else if (stream.valid && stream.ready) begin
      fvalid <= 1'b1;
    end else if (push.ready) begin
      fvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      fitem <= '{data_byte: req.data_byte, first_byte: req.first_byte, tag: tag};
    end
  end
endmodule

@@ rtl/core/pled_fifo.sv @@
// Short queue of classified bytes between the front and back stages.
// Depends on pled_pkg and pled_stream_if.
module pled_fifo #(
  parameter int Depth = pled_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  pled_stream_if.sink                  push,
  pled_stream_if.source                pop,
  output logic [$clog2(Depth+1)-1:0]   level
);
  import pled_pkg::*;

  localparam int PtrW   = $clog2(Depth);
  localparam int LevelW = $clog2(Depth + 1);

  item_t             mem [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic              do_push;
  logic              do_pop;

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign push.ready  = (level != LevelW'(Depth));
  assign pop.valid   = (level != '0);
  assign pop.payload = mem[rd_ptr];
  assign do_push     = push.valid && push.ready;
  assign do_pop      = pop.valid && pop.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) wr_ptr <= bump(wr_ptr);
      if (do_pop)  rd_ptr <= bump(rd_ptr);
      case ({do_push, do_pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push.payload;
  end
endmodule

@@ rtl/core/pled_back.sv @@
// Back stage: list-pack parser state machine and result output register.
// Depends on pled_pkg and pled_stream_if.
module pled_back (
  input logic           clk,
  input logic           rst,
  pled_stream_if.sink   queue,
  pled_stream_if.source result
);
  import pled_pkg::*;

  phase_t      phase, phase_next;
  logic [2:0]  hdr_pos, hdr_pos_next;
  logic [31:0] size_seen, size_seen_next;
  logic [15:0] count_seen, count_seen_next;
  logic [63:0] acc, acc_next;
  logic [31:0] bytes_left, bytes_left_next;
  enc_t        cur_enc, cur_enc_next;
  logic [32:0] entry_len, entry_len_next;
  logic [15:0] entry_cnt, entry_cnt_next;

  logic        out_valid;
  result_t     out_buf;

  item_t       item;
  logic [7:0]  b;
  logic        take;
  logic        emit;
  result_t     res;

  phase_t      ph_e;
  logic [2:0]  hp_e;
  logic [31:0] sz_e;
  logic [15:0] ct_e;
  logic [63:0] acc_e;
  logic [31:0] bl_e;
  enc_t        enc_e;
  logic [32:0] elen_e;
  logic [15:0] cnt_e;

  logic [31:0] bl_dec;
  logic [63:0] acc_sh;
  logic        do_str;
  logic [31:0] str_len;
  logic [32:0] str_total;
  logic        do_fin;
  logic [32:0] fin_len;

  assign item           = queue.payload;
  assign b              = item.data_byte;
  assign queue.ready    = !out_valid || result.ready;
  assign take           = queue.valid && queue.ready;
  assign result.valid   = out_valid;
  assign result.payload = out_buf;

  always_comb begin
    ph_e   = item.first_byte ? PH_HEADER : phase;
    hp_e   = item.first_byte ? 3'd0 : hdr_pos;
    sz_e   = item.first_byte ? '0 : size_seen;
    ct_e   = item.first_byte ? '0 : count_seen;
    acc_e  = item.first_byte ? '0 : acc;
    bl_e   = item.first_byte ? '0 : bytes_left;
    enc_e  = item.first_byte ? ENC_U7 : cur_enc;
    elen_e = item.first_byte ? '0 : entry_len;
    cnt_e  = item.first_byte ? '0 : entry_cnt;

    phase_next      = ph_e;
    hdr_pos_next    = hp_e;
    size_seen_next  = sz_e;
    count_seen_next = ct_e;
    acc_next        = acc_e;
    bytes_left_next = bl_e;
    cur_enc_next    = enc_e;
    entry_len_next  = elen_e;
    entry_cnt_next  = cnt_e;

    bl_dec    = (bl_e == '0) ? '0 : bl_e - 1'b1;
    acc_sh    = {acc_e[55:0], b};
    emit      = 1'b0;
    res       = '0;
    do_str    = 1'b0;
    str_len   = '0;
    do_fin    = 1'b0;
    fin_len   = '0;
    str_total = '0;

    case (ph_e)
      PH_HEADER: begin
        if (hp_e < 3'd4) size_seen_next = {sz_e[23:0], b};
        else count_seen_next = {ct_e[7:0], b};
        hdr_pos_next = hp_e + 3'd1;
        if (hdr_pos_next >= 3'd6) begin
          hdr_pos_next    = 3'd6;
          phase_next      = PH_TAG;
          emit            = 1'b1;
          res.kind        = KIND_HEADER;
          res.size_field  = size_seen_next;
          res.count_field = count_seen_next;
        end
      end
      PH_TAG: begin
        if (item.tag.is_end) begin
          emit             = 1'b1;
          res.kind         = KIND_END;
          res.entry_number = cnt_e;
          phase_next       = PH_DONE;
        end else begin
          cur_enc_next = item.tag.enc;
          case (item.tag.enc)
            ENC_U7: begin
              emit              = 1'b1;
              res.kind          = KIND_INT;
              res.int_value     = {57'd0, b[6:0]};
              res.encoding      = ENC_U7;
              res.entry_number  = cnt_e;
              res.last_of_entry = 1'b1;
              do_fin            = 1'b1;
              fin_len           = 33'd1;
            end
            ENC_S6: begin
              do_str  = 1'b1;
              str_len = {26'd0, b[5:0]};
            end
            ENC_I13: begin
              acc_next        = {59'd0, b[4:0]};
              bytes_left_next = 32'd1;
              phase_next      = PH_INT;
            end
            ENC_S12: begin
              acc_next        = {60'd0, b[3:0]};
              bytes_left_next = 32'd1;
              phase_next      = PH_LEN;
            end
            ENC_I16: begin
              acc_next        = '0;
              bytes_left_next = 32'd2;
              phase_next      = PH_INT;
            end
            ENC_I24: begin
              acc_next        = '0;
              bytes_left_next = 32'd3;
              phase_next      = PH_INT;
            end
            ENC_I32: begin
              acc_next        = '0;
              bytes_left_next = 32'd4;
              phase_next      = PH_INT;
            end
            ENC_I64: begin
              acc_next        = '0;
              bytes_left_next = 32'd8;
              phase_next      = PH_INT;
            end
            default: begin
              cur_enc_next    = ENC_S32;
              acc_next        = '0;
              bytes_left_next = 32'd4;
              phase_next      = PH_LEN;
            end
          endcase
        end
      end
      PH_INT: begin
        acc_next        = acc_sh;
        bytes_left_next = bl_dec;
        if (bl_dec == '0) begin
          emit              = 1'b1;
          res.kind          = KIND_INT;
          res.int_value     = sign_ext(acc_sh, enc_e);
          res.encoding      = enc_e;
          res.entry_number  = cnt_e;
          res.last_of_entry = 1'b1;
          do_fin            = 1'b1;
          fin_len           = {29'd0, head_size(enc_e)};
        end
      end
      PH_LEN: begin
        acc_next        = {32'd0, acc_e[23:0], b};
        bytes_left_next = bl_dec;
        if (bl_dec == '0) begin
          do_str  = 1'b1;
          str_len = {acc_e[23:0], b};
        end
      end
      PH_PAYLOAD: begin
        bytes_left_next   = bl_dec;
        emit              = 1'b1;
        res.kind          = KIND_BYTE;
        res.payload_byte  = b;
        res.string_length = acc_e[31:0];
        res.encoding      = enc_e;
        res.entry_number  = cnt_e;
        res.last_of_entry = (bl_dec == '0);
        if (bl_dec == '0) begin
          do_fin  = 1'b1;
          fin_len = elen_e;
        end
      end
      PH_BACKLEN: begin
        bytes_left_next = bl_dec;
        if (bl_dec == '0) phase_next = PH_TAG;
      end
      default: begin
        phase_next = ph_e;
      end
    endcase

    if (do_str) begin
      str_total = {29'd0, head_size(cur_enc_next)} + {1'b0, str_len};
      acc_next  = {32'd0, str_len};
      if (str_len == '0) begin
        emit              = 1'b1;
        res.kind          = KIND_EMPTY;
        res.encoding      = cur_enc_next;
        res.entry_number  = cnt_e;
        res.last_of_entry = 1'b1;
        do_fin            = 1'b1;
        fin_len           = str_total;
      end else begin
        entry_len_next  = str_total;
        bytes_left_next = str_len;
        phase_next      = PH_PAYLOAD;
      end
    end

    if (do_fin) begin
      entry_len_next  = fin_len;
      bytes_left_next = {29'd0, backlen_count(fin_len)};
      phase_next      = PH_BACKLEN;
      if (cnt_e != 16'hFFFF) entry_cnt_next = cnt_e + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      hdr_pos    <= '0;
      size_seen  <= '0;
      count_seen <= '0;
      acc        <= '0;
      bytes_left <= '0;
      cur_enc    <= ENC_U7;
      entry_len  <= '0;
      entry_cnt  <= '0;
    end else if (take) begin
      phase      <= phase_next;
      hdr_pos    <= hdr_pos_next;
      size_seen  <= size_seen_next;
      count_seen <= count_seen_next;
      acc        <= acc_next;
      bytes_left <= bytes_left_next;
      cur_enc    <= cur_enc_next;
      entry_len  <= entry_len_next;
      entry_cnt  <= entry_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) out_buf <= res;
  end
endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Testbench for packed_list_entry_decoder: drives packed list images one byte per request,
// predicts each result with a local list decoder and checks results in order, field by field.
// Depends on pled_pkg, pled_stream_if and the decoder RTL.
module tb;
  import pled_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 16;

  localparam logic [7:0] TAG_S32 = 8'hF0;
  localparam logic [7:0] TAG_I16 = 8'hF1;
  localparam logic [7:0] TAG_I24 = 8'hF2;
  localparam logic [7:0] TAG_I32 = 8'hF3;
  localparam logic [7:0] TAG_I64 = 8'hF4;
  localparam logic [7:0] TAG_END = 8'hFF;
  localparam logic [1:0] PFX_S6 = 2'b10;
  localparam logic [2:0] PFX_I13 = 3'b110;
  localparam logic [3:0] PFX_S12 = 4'hE;

  logic clk;
  logic rst;

  pled_stream_if #(.T(in_t)) stream_ch ();
  pled_stream_if #(.T(result_t)) result_ch ();

  packed_list_entry_decoder dut (
    .clk(clk),
    .rst(rst),
    .stream(stream_ch),
    .result(result_ch)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // local list decoder state
  phase_t      lp_phase;
  logic [2:0]  hdr_pos;
  logic [31:0] hdr_size;
  logic [15:0] hdr_count;
  logic [63:0] acc;
  logic [31:0] left;
  enc_t        cur_enc;
  logic [32:0] ent_len;
  logic [15:0] ent_cnt;

  result_t     pending_results[$];
  logic [7:0]  image[$];

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int fail_count = 0;
  int useful_bytes = 0;
  int result_index = 0;
  int quiet_cycles = 0;

  function automatic void add_byte(input logic [7:0] v);
    image.insert(image.size(), v);
  endfunction

  function automatic void clear_parser();
    lp_phase  = PH_HEADER;
    hdr_pos   = '0;
    hdr_size  = '0;
    hdr_count = '0;
    acc       = '0;
    left      = '0;
    cur_enc   = ENC_U7;
    ent_len   = '0;
    ent_cnt   = '0;
  endfunction

  function automatic logic [3:0] overhead(input enc_t e);
    case (e)
      ENC_U7, ENC_S6:   return 4'd1;
      ENC_I13, ENC_S12: return 4'd2;
      ENC_I16:          return 4'd3;
      ENC_I24:          return 4'd4;
      ENC_I32, ENC_S32: return 4'd5;
      default:          return 4'd9;
    endcase
  endfunction

  function automatic int enc_width(input enc_t e);
    case (e)
      ENC_U7:  return 7;
      ENC_I13: return 13;
      ENC_I16: return 16;
      ENC_I24: return 24;
      ENC_I32: return 32;
      default: return 64;
    endcase
  endfunction

  function automatic int trailer_len(input logic [32:0] n);
    if (n < (33'd1 << 7)) return 1;
    if (n < (33'd1 << 14)) return 2;
    if (n < (33'd1 << 21)) return 3;
    if (n < (33'd1 << 28)) return 4;
    return 5;
  endfunction

  function automatic logic [63:0] sext(input logic [63:0] v, input int w);
    logic [63:0] t;
    if (w >= 64) return v;
    t = v << (64 - w);
    return $signed(t) >>> (64 - w);
  endfunction

  function automatic void close_entry(input logic [32:0] n);
    ent_len  = n;
    left     = trailer_len(n);
    lp_phase = PH_BACKLEN;
    if (ent_cnt != 16'hFFFF) ent_cnt++;
  endfunction

  function automatic bit begin_string(input logic [31:0] len, output result_t r);
    logic [32:0] total;
    r = '0;
    total = {29'd0, overhead(cur_enc)} + {1'b0, len};
    acc = {32'd0, len};
    if (len == 0) begin
      r.kind = KIND_EMPTY;
      r.encoding = cur_enc;
      r.entry_number = ent_cnt;
      r.last_of_entry = 1'b1;
      close_entry(total);
      return 1'b1;
    end
    ent_len  = total;
    left     = len;
    lp_phase = PH_PAYLOAD;
    return 1'b0;
  endfunction

  function automatic bit decode_tag(input logic [7:0] b, output result_t r);
    r = '0;
    if (b == TAG_END) begin
      r.kind = KIND_END;
      r.entry_number = ent_cnt;
      lp_phase = PH_DONE;
      return 1'b1;
    end
    if (!b[7]) begin
      cur_enc = ENC_U7;
      r.kind = KIND_INT;
      r.int_value = {57'd0, b[6:0]};
      r.encoding = ENC_U7;
      r.entry_number = ent_cnt;
      r.last_of_entry = 1'b1;
      close_entry(33'd1);
      return 1'b1;
    end
    if (b[7:6] == PFX_S6) begin
      cur_enc = ENC_S6;
      return begin_string({26'd0, b[5:0]}, r);
    end
    if (b[7:5] == PFX_I13) begin
      cur_enc = ENC_I13;
      acc = {59'd0, b[4:0]};
      left = 1;
      lp_phase = PH_INT;
      return 1'b0;
    end
    if (b[7:4] == PFX_S12) begin
      cur_enc = ENC_S12;
      acc = {60'd0, b[3:0]};
      left = 1;
      lp_phase = PH_LEN;
      return 1'b0;
    end
    acc = '0;
    case (b)
      TAG_I16: begin cur_enc = ENC_I16; left = 2; lp_phase = PH_INT; end
      TAG_I24: begin cur_enc = ENC_I24; left = 3; lp_phase = PH_INT; end
      TAG_I32: begin cur_enc = ENC_I32; left = 4; lp_phase = PH_INT; end
      TAG_I64: begin cur_enc = ENC_I64; left = 8; lp_phase = PH_INT; end
      default: begin cur_enc = ENC_S32; left = 4; lp_phase = PH_LEN; end
    endcase
    return 1'b0;
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, input logic restart,
                                     output result_t r);
    r = '0;
    if (restart) clear_parser();
    case (lp_phase)
      PH_HEADER: begin
        if (hdr_pos < 4) hdr_size = {hdr_size[23:0], b};
        else hdr_count = {hdr_count[7:0], b};
        hdr_pos++;
        if (hdr_pos >= 6) begin
          hdr_pos = 3'd6;
          lp_phase = PH_TAG;
          r.kind = KIND_HEADER;
          r.size_field = hdr_size;
          r.count_field = hdr_count;
          return 1'b1;
        end
        return 1'b0;
      end
      PH_TAG: return decode_tag(b, r);
      PH_INT: begin
        acc = {acc[55:0], b};
        if (left != 0) left--;
        if (left == 0) begin
          r.kind = KIND_INT;
          r.int_value = sext(acc, enc_width(cur_enc));
          r.encoding = cur_enc;
          r.entry_number = ent_cnt;
          r.last_of_entry = 1'b1;
          close_entry({29'd0, overhead(cur_enc)});
          return 1'b1;
        end
        return 1'b0;
      end
      PH_LEN: begin
        acc = {32'd0, acc[23:0], b};
        if (left != 0) left--;
        if (left == 0) return begin_string(acc[31:0], r);
        return 1'b0;
      end
      PH_PAYLOAD: begin
        if (left != 0) left--;
        r.kind = KIND_BYTE;
        r.payload_byte = b;
        r.string_length = acc[31:0];
        r.encoding = cur_enc;
        r.entry_number = ent_cnt;
        r.last_of_entry = (left == 0);
        if (left == 0) close_entry(ent_len);
        return 1'b1;
      end
      PH_BACKLEN: begin
        if (left != 0) left--;
        if (left == 0) lp_phase = PH_TAG;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report(input string msg);
    fail_count++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic compare_field(input int idx, input string name, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want)
      report($sformatf("result %0d %s: got %0h, want %0h", idx, name, got, want));
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    result_index++;
    if (pending_results.size() == 0) begin
      report($sformatf("result %0d arrived with none pending", result_index));
      return;
    end
    want = pending_results.pop_front();
    compare_field(result_index, "kind", 64'(got.kind), 64'(want.kind));
    compare_field(result_index, "int_value", got.int_value, want.int_value);
    compare_field(result_index, "payload_byte", 64'(got.payload_byte),
                  64'(want.payload_byte));
    compare_field(result_index, "string_length", 64'(got.string_length),
                  64'(want.string_length));
    compare_field(result_index, "encoding", 64'(got.encoding), 64'(want.encoding));
    compare_field(result_index, "entry_number", 64'(got.entry_number),
                  64'(want.entry_number));
    compare_field(result_index, "last_of_entry", 64'(got.last_of_entry),
                  64'(want.last_of_entry));
    compare_field(result_index, "size_field", 64'(got.size_field), 64'(want.size_field));
    compare_field(result_index, "count_field", 64'(got.count_field),
                  64'(want.count_field));
  endtask

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) check_result(result_ch.payload);
  end

  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      result_ch.ready <= !rst && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (stream_ch.valid && stream_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] value, input logic restart);
    result_t res;
    in_t     req;
    while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      stream_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req.data_byte = value;
    req.first_byte = restart;
    stream_ch.valid <= 1'b1;
    stream_ch.payload <= req;
    do @(posedge clk); while (stream_ch.ready !== 1'b1);
    if (restart || lp_phase != PH_DONE) useful_bytes++;
    if (decode_byte(value, restart, res)) pending_results.insert(pending_results.size(), res);
  endtask

  task automatic wait_drained();
    stream_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_image(input bit restart);
    foreach (image[i]) send_byte(image[i], restart && i == 0);
    image.delete();
  endtask

  function automatic void put_header(input logic [31:0] size, input logic [15:0] count);
    for (int i = 3; i >= 0; i--) add_byte(size[8*i +: 8]);
    add_byte(count[15:8]);
    add_byte(count[7:0]);
  endfunction

  function automatic void put_trailer(input logic [32:0] n);
    repeat (trailer_len(n)) add_byte(8'($urandom_range(255)));
  endfunction

  function automatic void put_int(input enc_t e, input logic [63:0] v);
    int nbytes;
    case (e)
      ENC_U7:  begin add_byte({1'b0, v[6:0]}); nbytes = 0; end
      ENC_I13: begin add_byte({PFX_I13, v[12:8]}); nbytes = 1; end
      ENC_I16: begin add_byte(TAG_I16); nbytes = 2; end
      ENC_I24: begin add_byte(TAG_I24); nbytes = 3; end
      ENC_I32: begin add_byte(TAG_I32); nbytes = 4; end
      default: begin add_byte(TAG_I64); nbytes = 8; end
    endcase
    for (int i = nbytes - 1; i >= 0; i--) add_byte(v[8*i +: 8]);
    put_trailer({29'd0, overhead(e)});
  endfunction

  function automatic void put_str_head(input enc_t e, input logic [31:0] len,
                                       input logic [7:0] wide_tag);
    case (e)
      ENC_S6: add_byte({PFX_S6, len[5:0]});
      ENC_S12: begin
        add_byte({PFX_S12, len[11:8]});
        add_byte(len[7:0]);
      end
      default: begin
        add_byte(wide_tag);
        for (int i = 3; i >= 0; i--) add_byte(len[8*i +: 8]);
      end
    endcase
  endfunction

  function automatic void put_str(input enc_t e, input logic [31:0] len,
                                  input logic [7:0] wide_tag);
    put_str_head(e, len, wide_tag);
    repeat (len) add_byte(8'($urandom_range(255)));
    put_trailer({29'd0, overhead(e)} + {1'b0, len});
  endfunction

  function automatic logic [7:0] wide_tag();
    logic [7:0] t;
    t = 8'($urandom_range(10));
    return (t == 0) ? TAG_S32 : TAG_I64 + t;
  endfunction

  function automatic logic [63:0] pick_int(input int w);
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(5))
      0: r = 64'd1 << (w - 1);
      1: r = (64'd1 << (w - 1)) - 1;
      2: r = '1;
      3: r = '0;
      default: ;
    endcase
    return r;
  endfunction

  function automatic void put_random_entry();
    enc_t e;
    e = enc_t'($urandom_range(8));
    case (e)
      ENC_S6:
        put_str(e, ($urandom_range(3) == 0) ? 0 : $urandom_range(63), TAG_S32);
      ENC_S12:
        put_str(e, ($urandom_range(7) == 0) ? $urandom_range(300, 100) : $urandom_range(40),
                TAG_S32);
      ENC_S32:
        put_str(e, ($urandom_range(7) == 0) ? $urandom_range(200, 120) : $urandom_range(20),
                wide_tag());
      default: put_int(e, pick_int(enc_width(e)));
    endcase
  endfunction

  task automatic random_list();
    int pick;
    int cut;
    put_header($urandom, 16'($urandom_range(65535)));
    repeat ($urandom_range(8)) put_random_entry();
    add_byte(TAG_END);
    repeat ($urandom_range(3)) add_byte(8'($urandom_range(255)));
    pick = $urandom_range(99);
    if (pick < 10) begin
      cut = $urandom_range(image.size() - 1, 1);
      while (image.size() > cut) void'(image.pop_back());
      send_image(1'b1);
    end else if (pick < 18) begin
      image.delete();
      repeat ($urandom_range(20, 1))
        send_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
    end else begin
      send_image(1'b1);
    end
  endtask

  task automatic random_lists(input int target);
    int start;
    start = useful_bytes;
    while (useful_bytes - start < target) random_list();
  endtask

  // first list after reset carries no first-byte flag; bytes after the end are dropped
  task automatic test_start_without_flag();
    put_header(32'hFFFF_FFFF, 16'hFFFF);
    put_int(ENC_U7, 64'd0);
    add_byte(TAG_END);
    add_byte(8'($urandom_range(255)));
    add_byte(TAG_END);
    send_image(1'b0);
  endtask

  task automatic test_integer_encodings();
    int w;
    put_header(32'd0, 16'd0);
    put_int(ENC_U7, 64'h7F);
    for (int k = ENC_I13; k <= ENC_I64; k++) begin
      w = enc_width(enc_t'(k));
      put_int(enc_t'(k), (k % 2 == 1) ? (64'd1 << (w - 1)) : ((64'd1 << (w - 1)) - 1));
    end
    add_byte(TAG_END);
    send_image(1'b1);
  endtask

  task automatic test_string_encodings();
    put_header($urandom, 16'($urandom_range(65535)));
    put_str(ENC_S6, 0, TAG_S32);
    put_str_head(ENC_S6, 2, TAG_S32);
    add_byte(TAG_END);
    add_byte(TAG_END);
    put_trailer(33'd3);
    put_str(ENC_S12, 0, TAG_S32);
    put_str(ENC_S12, 3, TAG_S32);
    put_str(ENC_S32, 0, TAG_S32);
    for (int t = TAG_I64 + 1; t < TAG_END; t++) put_str(ENC_S32, t % 2, t[7:0]);
    add_byte(TAG_END);
    send_image(1'b1);
  endtask

  // restart in a payload, an integer, the header and a trailer
  task automatic test_restart_midway();
    put_header($urandom, 16'($urandom_range(65535)));
    put_str_head(ENC_S32, 32'hFFFF_FFFF, wide_tag());
    repeat (3) add_byte(8'($urandom_range(255)));
    send_image(1'b1);
    put_header($urandom, 16'($urandom_range(65535)));
    add_byte(TAG_I64);
    repeat (3) add_byte(8'($urandom_range(255)));
    send_image(1'b1);
    repeat (3) add_byte(8'($urandom_range(255)));
    send_image(1'b1);
    put_header($urandom, 16'($urandom_range(65535)));
    put_str(ENC_S12, 130, TAG_S32);
    void'(image.pop_back());
    send_image(1'b1);
    put_header($urandom, 16'($urandom_range(65535)));
    add_byte(TAG_END);
    send_image(1'b1);
  endtask

  // trailer length steps at entry length 128
  task automatic test_long_strings();
    put_header($urandom, 16'($urandom_range(65535)));
    put_str(ENC_S6, 63, TAG_S32);
    put_str(ENC_S12, 125, TAG_S32);
    put_str(ENC_S32, 123, wide_tag());
    put_int(ENC_U7, pick_int(7));
    add_byte(TAG_END);
    send_image(1'b1);
  endtask

  initial begin
    rst <= 1'b1;
    stream_ch.valid <= 1'b0;
    stream_ch.payload <= '0;
    clear_parser();
    src_idle_pct = 33;
    snk_idle_pct = 52;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_start_without_flag();
    test_integer_encodings();
    test_string_encodings();
    test_restart_midway();
    wait_drained();
    test_long_strings();
    random_lists(370);
    wait_drained();

    src_idle_pct = 52;
    snk_idle_pct = 33;
    random_lists(370);
    wait_drained();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    random_lists(370);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
